### sv/sm4_pkg.sv
`timescale 1ns / 1ps

package sm4_pkg;

	localparam int ROUND_COUNT_DEF = 32;

	localparam logic OP_KEY = 1'b0;
	localparam logic OP_ENC = 1'b1;

	localparam logic [7:0] SBOX [256] = '{
		8'hd6,8'h90,8'he9,8'hfe,8'hcc,8'he1,8'h3d,8'hb7,8'h16,8'hb6,8'h14,8'hc2,8'h28,8'hfb,8'h2c,8'h05,
		8'h2b,8'h67,8'h9a,8'h76,8'h2a,8'hbe,8'h04,8'hc3,8'haa,8'h44,8'h13,8'h26,8'h49,8'h86,8'h06,8'h99,
		8'h9c,8'h42,8'h50,8'hf4,8'h91,8'hef,8'h98,8'h7a,8'h33,8'h54,8'h0b,8'h43,8'hed,8'hcf,8'hac,8'h62,
		8'he4,8'hb3,8'h1c,8'ha9,8'hc9,8'h08,8'he8,8'h95,8'h80,8'hdf,8'h94,8'hfa,8'h75,8'h8f,8'h3f,8'ha6,
		8'h47,8'h07,8'ha7,8'hfc,8'hf3,8'h73,8'h17,8'hba,8'h83,8'h59,8'h3c,8'h19,8'he6,8'h85,8'h4f,8'ha8,
		8'h68,8'h6b,8'h81,8'hb2,8'h71,8'h64,8'hda,8'h8b,8'hf8,8'heb,8'h0f,8'h4b,8'h70,8'h56,8'h9d,8'h35,
		8'h1e,8'h24,8'h0e,8'h5e,8'h63,8'h58,8'hd1,8'ha2,8'h25,8'h22,8'h7c,8'h3b,8'h01,8'h21,8'h78,8'h87,
		8'hd4,8'h00,8'h46,8'h57,8'h9f,8'hd3,8'h27,8'h52,8'h4c,8'h36,8'h02,8'he7,8'ha0,8'hc4,8'hc8,8'h9e,
		8'hea,8'hbf,8'h8a,8'hd2,8'h40,8'hc7,8'h38,8'hb5,8'ha3,8'hf7,8'hf2,8'hce,8'hf9,8'h61,8'h15,8'ha1,
		8'he0,8'hae,8'h5d,8'ha4,8'h9b,8'h34,8'h1a,8'h55,8'had,8'h93,8'h32,8'h30,8'hf5,8'h8c,8'hb1,8'he3,
		8'h1d,8'hf6,8'he2,8'h2e,8'h82,8'h66,8'hca,8'h60,8'hc0,8'h29,8'h23,8'hab,8'h0d,8'h53,8'h4e,8'h6f,
		8'hd5,8'hdb,8'h37,8'h45,8'hde,8'hfd,8'h8e,8'h2f,8'h03,8'hff,8'h6a,8'h72,8'h6d,8'h6c,8'h5b,8'h51,
		8'h8d,8'h1b,8'haf,8'h92,8'hbb,8'hdd,8'hbc,8'h7f,8'h11,8'hd9,8'h5c,8'h41,8'h1f,8'h10,8'h5a,8'hd8,
		8'h0a,8'hc1,8'h31,8'h88,8'ha5,8'hcd,8'h7b,8'hbd,8'h2d,8'h74,8'hd0,8'h12,8'hb8,8'he5,8'hb4,8'hb0,
		8'h89,8'h69,8'h97,8'h4a,8'h0c,8'h96,8'h77,8'h7e,8'h65,8'hb9,8'hf1,8'h09,8'hc5,8'h6e,8'hc6,8'h84,
		8'h18,8'hf0,8'h7d,8'hec,8'h3a,8'hdc,8'h4d,8'h20,8'h79,8'hee,8'h5f,8'h3e,8'hd7,8'hcb,8'h39,8'h48
	};

	function automatic logic [31:0] tau(input logic [31:0] w);
		return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
	endfunction

	function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic logic [31:0] lin_mix(input logic [31:0] b);
		return b ^ rotl(b, 2) ^ rotl(b, 10) ^ rotl(b, 18) ^ rotl(b, 24);
	endfunction

endpackage

### sv/sm4_round.sv
`timescale 1ns / 1ps

module sm4_round
	import sm4_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         en,
	input  logic         v_in,
	input  logic [127:0] x_in,
	input  logic [31:0]  rk,
	output logic         v_out,
	output logic [127:0] x_out
);

	logic         valid_s1;
	logic [127:0] state_s1;
	logic [31:0]  nxt;

	assign nxt = x_in[127:96] ^ lin_mix(tau(x_in[95:64] ^ x_in[63:32] ^ x_in[31:0] ^ rk));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= v_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			state_s1 <= {x_in[95:0], nxt};
		end
	end

	assign v_out = valid_s1;
	assign x_out = state_s1;

endmodule

### sv/sm4_block_encrypt.sv
`timescale 1ns / 1ps

// SM4 encryption pipeline, one round per register stage.
// Input channel (blk_valid / blk_stall): opcode 0 loads one round key at
// key_index, opcode 1 carries a 128-bit big-endian block. All round keys must
// be loaded before the first block is sent; decryption uses the keys loaded
// in reverse order.
// Output channel (res_valid / res_stall): one ciphertext per block transfer,
// in the order the blocks were taken.
// A block's result is offered once it has passed all ROUND_COUNT rounds and
// leaves when res_stall is low; the pipeline accepts a new block every cycle
// unless a held result stalls it. A key load waits, with blk_stall high, until
// no block is left in the rounds or the output register, so that every block
// sees the keys that were in place when it was taken.
// When res_stall is high with a result waiting, the whole pipeline holds and
// blk_stall is raised; nothing is lost or repeated.
// Reset empties the pipeline; round key contents stay undefined until loaded.
module sm4_block_encrypt
	import sm4_pkg::*;
#(
	parameter int ROUND_COUNT = ROUND_COUNT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           blk_valid,
	output logic                           blk_stall,
	input  logic                           opcode,
	input  logic [$clog2(ROUND_COUNT)-1:0] key_index,
	input  logic [31:0]                    key_word,
	input  logic [63:0]                    block_upper,
	input  logic [63:0]                    block_lower,
	output logic                           res_valid,
	input  logic                           res_stall,
	output logic [63:0]                    cipher_upper,
	output logic [63:0]                    cipher_lower
);

	logic [31:0]  rk_q [ROUND_COUNT];
	logic [ROUND_COUNT:0] v;
	logic [127:0] x [ROUND_COUNT+1];
	logic adv, busy, key_xfer;

	assign busy      = |v[ROUND_COUNT:1];
	assign adv       = !v[ROUND_COUNT] || !res_stall;
	assign blk_stall = !adv || (opcode == OP_KEY && busy);
	assign key_xfer  = blk_valid && !blk_stall && opcode == OP_KEY;

	assign v[0] = blk_valid && !blk_stall && opcode == OP_ENC;
	assign x[0] = {block_upper, block_lower};

	always_ff @(posedge clk) begin
		if (key_xfer) begin
			rk_q[key_index] <= key_word;
		end
	end

	for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
		sm4_round u_round (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (adv),
			.v_in  (v[r]),
			.x_in  (x[r]),
			.rk    (rk_q[r]),
			.v_out (v[r+1]),
			.x_out (x[r+1])
		);
	end

	assign res_valid    = v[ROUND_COUNT];
	assign cipher_upper = {x[ROUND_COUNT][31:0], x[ROUND_COUNT][63:32]};
	assign cipher_lower = {x[ROUND_COUNT][95:64], x[ROUND_COUNT][127:96]};

	a_key_idle: assert property (@(posedge clk) disable iff (!arst_n)
		key_xfer |-> !busy)
		else $error("key loaded while blocks in flight");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> v[ROUND_COUNT] && $stable(v[ROUND_COUNT:1]))
		else $error("pipeline moved while stalled");

	a_no_res_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy |-> !res_valid)
		else $error("result without any block in flight");

endmodule

### tb/sm4_block_encrypt_test.sv
`timescale 1ns / 1ps

module sm4_block_encrypt_test
	import sm4_pkg::*;
();

	localparam int NUM_RANDOM = 1170;
	localparam int STALL_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 80;

	class cipher_scoreboard;
		logic [31:0] key_table [32];
		logic [127:0] pending_cipher [$];
		int error_count;

		function new();
			error_count = 0;
			foreach (key_table[i])
				key_table[i] = '0;
		endfunction

		function logic [31:0] rotate_left(logic [31:0] v, int n);
			return (v << n) | (v >> (32 - n));
		endfunction

		function logic [31:0] round_func(logic [31:0] x);
			logic [31:0] b;
			b = {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
			return b ^ rotate_left(b, 2) ^ rotate_left(b, 10) ^ rotate_left(b, 18)
				^ rotate_left(b, 24);
		endfunction

		function void note_transfer(logic op, logic [4:0] idx, logic [31:0] kw,
				logic [63:0] up, logic [63:0] lo);
			logic [31:0] w [4];
			logic [31:0] nxt;
			if (op == OP_KEY) begin
				key_table[idx] = kw;
				return;
			end
			w[0] = up[63:32];
			w[1] = up[31:0];
			w[2] = lo[63:32];
			w[3] = lo[31:0];
			for (int r = 0; r < 32; r++) begin
				nxt = w[0] ^ round_func(w[1] ^ w[2] ^ w[3] ^ key_table[r]);
				w[0] = w[1];
				w[1] = w[2];
				w[2] = w[3];
				w[3] = nxt;
			end
			pending_cipher.push_back({w[3], w[2], w[1], w[0]});
		endfunction

		function void check_result(logic [63:0] up, logic [63:0] lo);
			logic [127:0] exp_cipher;
			if (pending_cipher.size() == 0) begin
				$error("unexpected result: cipher_upper=%h cipher_lower=%h", up, lo);
				error_count++;
				return;
			end
			exp_cipher = pending_cipher.pop_front();
			if (up !== exp_cipher[127:64]) begin
				$error("cipher_upper: expected %h, actual %h", exp_cipher[127:64], up);
				error_count++;
			end
			if (lo !== exp_cipher[63:0]) begin
				$error("cipher_lower: expected %h, actual %h", exp_cipher[63:0], lo);
				error_count++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic blk_valid = 1'b0;
	logic blk_stall;
	logic opcode = OP_KEY;
	logic [4:0] key_index = '0;
	logic [31:0] key_word = '0;
	logic [63:0] block_upper = '0;
	logic [63:0] block_lower = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [63:0] cipher_upper;
	logic [63:0] cipher_lower;

	cipher_scoreboard board = new();
	bit quiet_phase = 1'b0;
	bit long_hold = 1'b0;
	int idle_cycles = 0;

	sm4_block_encrypt dut (
		.clk(clk), .arst_n(arst_n),
		.blk_valid(blk_valid), .blk_stall(blk_stall),
		.opcode(opcode), .key_index(key_index), .key_word(key_word),
		.block_upper(block_upper), .block_lower(block_lower),
		.res_valid(res_valid), .res_stall(res_stall),
		.cipher_upper(cipher_upper), .cipher_lower(cipher_lower)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Scoreboard sampling and the idle-cycle watchdog.
	always @(posedge clk) begin
		if (arst_n) begin
			if (blk_valid && !blk_stall)
				board.note_transfer(opcode, key_index, key_word, block_upper, block_lower);
			if (res_valid && !res_stall)
				board.check_result(cipher_upper, cipher_lower);
			if ((blk_valid && !blk_stall) || (res_valid && !res_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// Receiver back-pressure: random bursts, one long hold, none at the end.
	initial begin
		int n;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (long_hold) begin
				res_stall <= 1'b1;
				repeat (150) @(posedge clk);
				long_hold = 1'b0;
				res_stall <= 1'b0;
			end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 8);
				res_stall <= 1'b1;
				repeat (n - 1) @(posedge clk);
				@(posedge clk);
				res_stall <= 1'b0;
			end
		end
	end

	task automatic send_item(logic op, logic [4:0] idx, logic [31:0] kw,
			logic [63:0] up, logic [63:0] lo);
		int gap;
		if (!quiet_phase && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 8);
			blk_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		blk_valid <= 1'b1;
		opcode <= op;
		key_index <= idx;
		key_word <= kw;
		block_upper <= up;
		block_lower <= lo;
		do
			@(posedge clk);
		while (blk_stall);
	endtask

	task automatic send_random_block();
		send_item(OP_ENC, 5'($urandom), $urandom,
			{$urandom, $urandom}, {$urandom, $urandom});
	endtask

	task automatic load_key_set(bit reversed);
		for (int i = 0; i < 32; i++)
			send_item(OP_KEY, reversed ? 5'(31 - i) : 5'(i), $urandom, 64'($urandom), '0);
	endtask

	task automatic wait_drained();
		blk_valid <= 1'b0;
		while (board.pending_cipher.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Full key schedule, then directed extremes of the block fields.
		for (int i = 0; i < 32; i++)
			send_item(OP_KEY, 5'(i), (i == 0) ? 32'h0 : (i == 31) ? 32'hffffffff : $urandom,
				'1, '1);
		send_item(OP_ENC, '1, '1, '0, '0);
		send_item(OP_ENC, '0, '0, '1, '1);
		send_item(OP_ENC, '0, '0, 64'h0123456789abcdef, 64'hfedcba9876543210);
		send_item(OP_ENC, '0, '0, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
		// A key rewrite with random block fields after blocks only affects later blocks.
		send_item(OP_KEY, 5'd31, 32'h0, {$urandom, $urandom}, {$urandom, $urandom});
		send_item(OP_ENC, '0, '0, 64'h0123456789abcdef, 64'hfedcba9876543210);

		// The sender pauses until all results are back.
		wait_drained();

		// The receiver holds off while blocks keep arriving.
		long_hold = 1'b1;
		for (int i = 0; i < 80; i++)
			send_random_block();

		for (int i = 0; i < NUM_RANDOM; i++) begin
			if (i == NUM_RANDOM - 200)
				quiet_phase = 1'b1;
			if ($urandom_range(0, 99) == 0)
				load_key_set($urandom_range(0, 1));
			else if ($urandom_range(0, 29) == 0)
				send_item(OP_KEY, 5'($urandom), $urandom,
					{$urandom, $urandom}, {$urandom, $urandom});
			else
				send_random_block();
		end

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (board.error_count == 0 && board.pending_cipher.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

### sm4_block_encrypt.f
sv/sm4_pkg.sv
sv/sm4_round.sv
sv/sm4_block_encrypt.sv
tb/sm4_block_encrypt_test.sv
